// ----- hdl/bq_pkg.sv -----
// ----------------------------------------------------------------------------
// bq_pkg: shared definitions for the multichannel biquad core
// Widths, configuration and state types, the sequencer states and the
// saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package bq_pkg;

  // Channel store geometry.
  localparam int CHANNELS = 8;
  localparam int CH_W     = 3;
  localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Sample and coefficient formats.
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_W      = 32;
  localparam int ACT_W       = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Delay state, Q7.40, split into two halves for the multiplier.
  localparam int ST_W   = 48;
  localparam int HALF_W = ST_W / 2;

  // Multiplier: coefficient times a sample or one half of a state word.
  localparam int MB_W   = ((SAMPLE_BITS > HALF_W) ? SAMPLE_BITS : HALF_W) + 1;
  localparam int PROD_W = COEF_W + MB_W;

  // Sample to Q7.40 shift, and the coefficient fraction bits.
  localparam int XSH    = 41 - SAMPLE_BITS;
  localparam int FRAC_W = 26;
  localparam int FF_SH  = FRAC_W - XSH;

  // Accumulator for one filter term plus a state, and the full feedback product.
  localparam int ACC_W = PROD_W + 1;
  localparam int W_W   = COEF_W + ST_W + 2;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0     = 3'd0,
    REG_B1     = 3'd1,
    REG_B2     = 3'd2,
    REG_A1     = 3'd3,
    REG_A2     = 3'd4,
    REG_ACTIVE = 3'd5
  } reg_idx_t;

  localparam logic [COEF_W-1:0] B0_RESET = 32'h0400_0000;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [ACT_W-1:0]         active;
  } coef_t;

  typedef struct packed {
    logic signed [ST_W-1:0] d1;
    logic signed [ST_W-1:0] d2;
  } st_pair_t;

  // Sequencer: idle, the multiply steps M0 to M7 of the shared multiplier, write-back and done.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_WB,
    ST_DONE
  } seq_state_t;

  // Saturate an accumulator value to the state width.
  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-ST_W:0] top;
    logic signed [ST_W-1:0] res;
    top = v[ACC_W-1:ST_W-1];
    if ((&top) || !(|top)) begin
      res = v[ST_W-1:0];
    end else if (v[ACC_W-1]) begin
      res = {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(ST_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Saturate an accumulator value to the sample width.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [ACC_W-1:0] v
  );
    logic [ACC_W-SAMPLE_BITS:0] top;
    logic signed [SAMPLE_BITS-1:0] res;
    top = v[ACC_W-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      res = v[SAMPLE_BITS-1:0];
    end else if (v[ACC_W-1]) begin
      res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ----- hdl/multichannel_biquad_df2t_core.sv -----
// ----------------------------------------------------------------------------
// multichannel_biquad_df2t_core: multichannel transposed direct form II biquad
// Filters samples tagged with a channel number through one shared
// second-order section, with two delay states per channel kept in memory.
// ----------------------------------------------------------------------------
// Use: the input channel takes one word of channel number and sample; the
// output channel returns one filtered sample per input word, in order.
// Coefficients (Q5.26) and the active channel count are written through the
// configuration channel while the core is idle; it is always ready.
// A word for an active channel reads its delay pair from the state memory,
// forms seven products in turn on one shared multiplier, and writes the new
// pair back; it steps through M0 to M7, the write-back and the done state,
// and the next word is taken only once its result has entered the output
// register. A word for an inactive channel goes straight to the done state
// and returns its sample unchanged.
// The output register parts the two sides: a new word is taken while the
// previous result still waits. If the receiver stalls the finished result
// waits in a holding register and no further word is taken.
// Reset clears the delay states to zero (per-entry valid bits, no sweep),
// sets b0 to 1.0, the other coefficients and the active count to zero.
// ----------------------------------------------------------------------------
module multichannel_biquad_df2t_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [bq_pkg::CH_W-1:0]                in_channel,
  input  logic signed [bq_pkg::SAMPLE_BITS-1:0]  in_sample_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bq_pkg::SAMPLE_BITS-1:0]  out_sample_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bq_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [bq_pkg::CFG_DATA_W-1:0]          cfg_data
);

  localparam logic signed [bq_pkg::ACC_W-1:0] FF_HALF =
    bq_pkg::ACC_W'(1) << (bq_pkg::FF_SH - 1);
  localparam logic signed [bq_pkg::ACC_W-1:0] OUT_HALF =
    bq_pkg::ACC_W'(1) << (bq_pkg::XSH - 1);
  localparam logic signed [bq_pkg::W_W-1:0] FB_HALF =
    bq_pkg::W_W'(1) << (bq_pkg::FRAC_W - 1);

  bq_pkg::coef_t       coef;
  bq_pkg::st_pair_t    rd_data;
  bq_pkg::st_pair_t    wr_data;
  bq_pkg::seq_state_t  state_r, state_nxt;

  logic                                  in_acc;
  logic                                  ch_active;
  logic                                  out_load;
  logic                                  mem_we;

  logic [bq_pkg::CH_W-1:0]               ch_r, ch_nxt;
  logic signed [bq_pkg::SAMPLE_BITS-1:0] x_r, x_nxt;
  logic signed [bq_pkg::ST_W-1:0]        y_r, y_nxt;
  logic signed [bq_pkg::ACC_W-1:0]       t1_r, t1_nxt;
  logic signed [bq_pkg::ACC_W-1:0]       t2_r, t2_nxt;
  logic signed [bq_pkg::W_W-1:0]         w_r, w_nxt;
  logic signed [bq_pkg::SAMPLE_BITS-1:0] res_r, res_nxt;
  logic signed [bq_pkg::SAMPLE_BITS-1:0] out_data_r, out_data_nxt;
  logic                                  out_valid_r, out_valid_nxt;

  logic signed [bq_pkg::COEF_W-1:0]      mul_a;
  logic signed [bq_pkg::MB_W-1:0]        mul_b;
  logic signed [bq_pkg::PROD_W-1:0]      prod;
  logic signed [bq_pkg::ACC_W-1:0]       prod_ext;
  logic signed [bq_pkg::ACC_W-1:0]       ff_rnd;
  logic signed [bq_pkg::ACC_W-1:0]       fb_rnd;
  logic signed [bq_pkg::ACC_W-1:0]       y_sum;
  logic signed [bq_pkg::ACC_W-1:0]       t2_fin;
  logic signed [bq_pkg::ACC_W-1:0]       o_sum;
  logic signed [bq_pkg::MB_W-1:0]        x_op, yh_op, yl_op;

  // Configuration registers.
  bq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Delay state memory: read on acceptance, written back at the end.
  bq_state_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (bq_pkg::ADDR_W'(in_channel)),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (bq_pkg::ADDR_W'(ch_r)),
    .wr_data (wr_data)
  );

  // Shared multiplier.
  bq_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Handshake and channel decode.
  assign in_ready       = (state_r == bq_pkg::ST_IDLE);
  assign in_acc         = in_valid && in_ready;
  assign ch_active      = ({1'b0, in_channel} < coef.active) &&
                          (32'(in_channel) < bq_pkg::CHANNELS);
  assign out_load       = (state_r == bq_pkg::ST_DONE) && (!out_valid_r || out_ready);
  assign mem_we         = (state_r == bq_pkg::ST_WB);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  // Multiplier operands: the sample and the two halves of y.
  assign x_op  = bq_pkg::MB_W'(x_r);
  assign yh_op = bq_pkg::MB_W'($signed(y_r[bq_pkg::ST_W-1:bq_pkg::HALF_W]));
  assign yl_op = {1'b0, y_r[bq_pkg::HALF_W-1:0]};

  // Rounded terms: feedforward products and the accumulated feedback product.
  assign prod_ext = bq_pkg::ACC_W'(prod);
  assign ff_rnd   = (prod_ext + FF_HALF) >>> bq_pkg::FF_SH;
  assign fb_rnd   = bq_pkg::ACC_W'((w_r + FB_HALF) >>> bq_pkg::FRAC_W);
  assign y_sum    = ff_rnd + bq_pkg::ACC_W'(rd_data.d1);
  assign t2_fin   = t2_r - fb_rnd;
  assign o_sum    = (bq_pkg::ACC_W'(y_r) + OUT_HALF) >>> bq_pkg::XSH;

  // Write-back pair.
  assign wr_data.d1 = bq_pkg::sat_st(t1_r);
  assign wr_data.d2 = bq_pkg::sat_st(t2_fin);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bq_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ch_active ? bq_pkg::ST_M0 : bq_pkg::ST_DONE;
        end
      end
      bq_pkg::ST_M0:   state_nxt = bq_pkg::ST_M1;
      bq_pkg::ST_M1:   state_nxt = bq_pkg::ST_M2;
      bq_pkg::ST_M2:   state_nxt = bq_pkg::ST_M3;
      bq_pkg::ST_M3:   state_nxt = bq_pkg::ST_M4;
      bq_pkg::ST_M4:   state_nxt = bq_pkg::ST_M5;
      bq_pkg::ST_M5:   state_nxt = bq_pkg::ST_M6;
      bq_pkg::ST_M6:   state_nxt = bq_pkg::ST_M7;
      bq_pkg::ST_M7:   state_nxt = bq_pkg::ST_WB;
      bq_pkg::ST_WB:   state_nxt = bq_pkg::ST_DONE;
      bq_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = bq_pkg::ST_IDLE;
        end
      end
      default:         state_nxt = bq_pkg::ST_IDLE;
    endcase
  end

  // Datapath control: operand selection and term accumulation per step.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    ch_nxt  = ch_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    t1_nxt  = t1_r;
    t2_nxt  = t2_r;
    w_nxt   = w_r;
    res_nxt = res_r;
    case (state_r)
      bq_pkg::ST_IDLE: begin
        if (in_acc) begin
          ch_nxt  = in_channel;
          x_nxt   = in_sample_in;
          res_nxt = in_sample_in;
        end
      end
      bq_pkg::ST_M0: begin
        mul_a = coef.b0;
        mul_b = x_op;
      end
      bq_pkg::ST_M1: begin
        y_nxt = bq_pkg::sat_st(y_sum);
        mul_a = coef.b1;
        mul_b = x_op;
      end
      bq_pkg::ST_M2: begin
        t1_nxt = ff_rnd + bq_pkg::ACC_W'(rd_data.d2);
        mul_a  = coef.b2;
        mul_b  = x_op;
      end
      bq_pkg::ST_M3: begin
        t2_nxt = ff_rnd;
        mul_a  = coef.a1;
        mul_b  = yh_op;
      end
      bq_pkg::ST_M4: begin
        w_nxt = bq_pkg::W_W'(prod) <<< bq_pkg::HALF_W;
        mul_a = coef.a1;
        mul_b = yl_op;
      end
      bq_pkg::ST_M5: begin
        w_nxt = w_r + bq_pkg::W_W'(prod);
        mul_a = coef.a2;
        mul_b = yh_op;
      end
      bq_pkg::ST_M6: begin
        t1_nxt = t1_r - fb_rnd;
        w_nxt  = bq_pkg::W_W'(prod) <<< bq_pkg::HALF_W;
        mul_a  = coef.a2;
        mul_b  = yl_op;
      end
      bq_pkg::ST_M7: begin
        w_nxt = w_r + bq_pkg::W_W'(prod);
      end
      bq_pkg::ST_WB: begin
        res_nxt = bq_pkg::sat_smp(o_sum);
      end
      bq_pkg::ST_DONE: begin
        res_nxt = res_r;
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    w_r        <= w_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // An inactive channel never reaches the multiply sequence.
  a_pass_skips_mem: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !ch_active |=> state_r == bq_pkg::ST_DONE)
    else $error("inactive channel entered the filter sequence");

  // An active channel starts the multiply sequence right after acceptance.
  a_active_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ch_active |=> state_r == bq_pkg::ST_M0)
    else $error("active channel did not start the filter sequence");

  // A finished result is presented once the output register is free.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == bq_pkg::ST_IDLE)
    else $error("finished result not presented");

  // The state write-back comes right after step M7.
  a_wb_after_m7: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> $past(state_r) == bq_pkg::ST_M7)
    else $error("state write-back out of sequence");

endmodule

// ----- hdl/bq_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bq_cfg_regs: coefficient and channel count registers
// Takes words from the configuration channel and holds the five shared
// coefficients and the active channel count. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module bq_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bq_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bq_pkg::coef_t                    coef
);

  bq_pkg::coef_t coef_r;
  bq_pkg::coef_t coef_nxt;

  // Registers are always ready to take a word.
  assign cfg_ready = 1'b1;
  assign coef      = coef_r;

  // Decode the register index of an accepted word.
  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid) begin
      case (cfg_index)
        bq_pkg::REG_B0:     coef_nxt.b0 = cfg_data[bq_pkg::COEF_W-1:0];
        bq_pkg::REG_B1:     coef_nxt.b1 = cfg_data[bq_pkg::COEF_W-1:0];
        bq_pkg::REG_B2:     coef_nxt.b2 = cfg_data[bq_pkg::COEF_W-1:0];
        bq_pkg::REG_A1:     coef_nxt.a1 = cfg_data[bq_pkg::COEF_W-1:0];
        bq_pkg::REG_A2:     coef_nxt.a2 = cfg_data[bq_pkg::COEF_W-1:0];
        bq_pkg::REG_ACTIVE: coef_nxt.active = cfg_data[bq_pkg::ACT_W-1:0];
        default:            coef_nxt = coef_r;
      endcase
    end
  end

  // Unity gain pass-band and no active channels after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0     <= bq_pkg::B0_RESET;
      coef_r.b1     <= '0;
      coef_r.b2     <= '0;
      coef_r.a1     <= '0;
      coef_r.a2     <= '0;
      coef_r.active <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

endmodule

// ----- hdl/bq_state_mem.sv -----
// ----------------------------------------------------------------------------
// bq_state_mem: per-channel delay state store
// One synchronous memory of delay pairs with a registered read port. A valid
// bit per entry makes entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module bq_state_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [bq_pkg::ADDR_W-1:0]     rd_addr,
  output bq_pkg::st_pair_t              rd_data,
  input  logic                          wr_en,
  input  logic [bq_pkg::ADDR_W-1:0]     wr_addr,
  input  bq_pkg::st_pair_t              wr_data
);

  bq_pkg::st_pair_t                mem_r [bq_pkg::CHANNELS];
  logic [bq_pkg::CHANNELS-1:0]     valid_r;
  bq_pkg::st_pair_t                rd_data_r;
  logic                            rd_valid_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Entry valid bits, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= mem_r[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// ----- hdl/bq_mul.sv -----
// ----------------------------------------------------------------------------
// bq_mul: shared registered multiplier
// Signed coefficient times a signed sample or state half, product registered.
// ----------------------------------------------------------------------------
module bq_mul (
  input  logic                                clk,
  input  logic signed [bq_pkg::COEF_W-1:0]    op_a,
  input  logic signed [bq_pkg::MB_W-1:0]      op_b,
  output logic signed [bq_pkg::PROD_W-1:0]    prod
);

  logic signed [bq_pkg::PROD_W-1:0] prod_r;

  // One product per cycle.
  always_ff @(posedge clk) begin
    prod_r <= bq_pkg::PROD_W'(op_a) * bq_pkg::PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

// ----- verif/tb_multichannel_biquad_df2t_core.sv -----
// ----------------------------------------------------------------------------
// tb_multichannel_biquad_df2t_core: self-checking bench for the biquad core
// Drives channel-tagged samples through the core under random sender bursts
// and receiver stalls. A bit-true model of the transposed direct form II
// section predicts every result, and each result word is checked in order.
// Coefficients and the active count are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_multichannel_biquad_df2t_core;

  import bq_pkg::*;

  // Wide signed type for exact products and sums before saturation.
  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic [CH_W-1:0]               channel;
    logic signed [SAMPLE_BITS-1:0] sample;
  } expected_word_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 260;

  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Coefficient ranges used when programming the filter.
  localparam int unsigned SPAN_FULL   = 0;
  localparam int unsigned SPAN_UNITY  = 32'd67108864;
  localparam int unsigned SPAN_DOUBLE = 32'd134217728;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COEF_W-1:0]             COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0]             COEF_MIN = 32'h8000_0000;

  localparam wide_t STATE_HI  = (wide_t'(1) <<< (ST_W - 1)) - 1;
  localparam wide_t STATE_LO  = -(wide_t'(1) <<< (ST_W - 1));
  localparam wide_t SAMPLE_HI = (wide_t'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam wide_t SAMPLE_LO = -(wide_t'(1) <<< (SAMPLE_BITS - 1));

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [CH_W-1:0]               in_channel;
  logic signed [SAMPLE_BITS-1:0] in_sample_in;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;

  // Mirror of the programmed registers and the per-channel delay states.
  coef_t          coef_mirror;
  st_pair_t       delay_mirror [CHANNELS];
  expected_word_t pending_samples [$];

  int          fail_count  = 0;
  int          burst_left  = 0;
  bit          steady_send = 1'b0;
  logic [15:0] ready_pattern;
  int          pattern_age = 0;
  int          quiet_cycles;

  multichannel_biquad_df2t_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_channel     (in_channel),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  // Coefficient times a Q7.40 value, rounded half up back to Q7.40.
  function automatic wide_t scale_q26(input logic signed [COEF_W-1:0] c, input wide_t v);
    wide_t p;
    p = wide_t'(c) * v;
    return (p + (wide_t'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  function automatic wide_t clamp_wide(input wide_t v, input wide_t lo, input wide_t hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Expected output of one word; advances the mirrored delay states.
  function automatic logic signed [SAMPLE_BITS-1:0] predict_filter(
    input logic [CH_W-1:0]               ch,
    input logic signed [SAMPLE_BITS-1:0] x
  );
    wide_t x40;
    wide_t y;
    wide_t d1_next;
    wide_t d2_next;
    wide_t o;
    if (ch >= coef_mirror.active || ch >= CHANNELS) return x;
    x40 = wide_t'(x) <<< XSH;
    y = clamp_wide(scale_q26($signed(coef_mirror.b0), x40)
                   + wide_t'($signed(delay_mirror[ch].d1)), STATE_LO, STATE_HI);
    d1_next = clamp_wide(scale_q26($signed(coef_mirror.b1), x40)
                         - scale_q26($signed(coef_mirror.a1), y)
                         + wide_t'($signed(delay_mirror[ch].d2)), STATE_LO, STATE_HI);
    d2_next = clamp_wide(scale_q26($signed(coef_mirror.b2), x40)
                         - scale_q26($signed(coef_mirror.a2), y), STATE_LO, STATE_HI);
    delay_mirror[ch].d1 = d1_next[ST_W-1:0];
    delay_mirror[ch].d2 = d2_next[ST_W-1:0];
    o = clamp_wide((y + (wide_t'(1) <<< (XSH - 1))) >>> XSH, SAMPLE_LO, SAMPLE_HI);
    return o[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [COEF_W-1:0] random_coef(input int unsigned span);
    if (span == SPAN_FULL) return $urandom();
    return COEF_W'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 15))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Send one word in the current burst; a new burst may start with a gap.
  task automatic send_word(
    input logic [CH_W-1:0]               ch,
    input logic signed [SAMPLE_BITS-1:0] smp
  );
    int gap;
    expected_word_t exp_word;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady_send ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_channel   <= ch;
    in_sample_in <= smp;
    do @(posedge clk); while (!in_ready);
    exp_word.channel = ch;
    exp_word.sample  = predict_filter(ch, smp);
    pending_samples.push_back(exp_word);
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic drain_block();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the mirror follows at the accepting edge.
  task automatic write_register(
    input logic [CFG_IDX_W-1:0]  idx,
    input logic [CFG_DATA_W-1:0] data
  );
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_B0:     coef_mirror.b0 = data;
      REG_B1:     coef_mirror.b1 = data;
      REG_B2:     coef_mirror.b2 = data;
      REG_A1:     coef_mirror.a1 = data;
      REG_A2:     coef_mirror.a2 = data;
      REG_ACTIVE: coef_mirror.active = data[ACT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Program all five coefficients and the active count; upper bits are noise.
  task automatic program_filter(input int unsigned ff_span, input int unsigned fb_span,
                                input logic [ACT_W-1:0] act);
    write_register(REG_B0, random_coef(ff_span));
    write_register(REG_B1, random_coef(ff_span));
    write_register(REG_B2, random_coef(ff_span));
    write_register(REG_A1, random_coef(fb_span));
    write_register(REG_A2, random_coef(fb_span));
    write_register(REG_ACTIVE, {28'($urandom() >> ACT_W), act});
  endtask

  // After reset no channel is active, so every word passes straight through.
  task automatic test_reset_passthrough();
    send_word(3'd0, SMP_MAX);
    send_word(3'd7, SMP_MIN);
    send_word(3'd3, '0);
    send_word(3'd5, '1);
    drain_block();
  endtask

  // Reset coefficients give a unity filter; spare indexes must change nothing.
  task automatic test_unity_and_spare_registers();
    write_register(REG_ACTIVE, CFG_DATA_W'(CHANNELS));
    send_word(3'd0, SMP_MAX);
    send_word(3'd7, SMP_MIN);
    send_word(3'd1, SAMPLE_BITS'(1));
    drain_block();
    write_register(REG_SPARE_LO, $urandom());
    write_register(REG_SPARE_HI, $urandom());
    send_word(3'd2, SMP_MAX);
    drain_block();
    // An active count beyond the channel count behaves as all channels.
    write_register(REG_ACTIVE, {(CFG_DATA_W){1'b1}});
    send_word(3'd7, '1);
    send_word(3'd4, SMP_MIN);
    drain_block();
  endtask

  // Extreme coefficients drive the output and both delay states to their limits.
  task automatic test_saturation();
    write_register(REG_B0, COEF_MAX);
    write_register(REG_B1, COEF_MAX);
    write_register(REG_B2, COEF_MAX);
    write_register(REG_A1, COEF_MIN);
    write_register(REG_A2, COEF_MIN);
    write_register(REG_ACTIVE, CFG_DATA_W'(CHANNELS));
    send_word(3'd0, SMP_MAX);
    send_word(3'd0, SMP_MAX);
    send_word(3'd0, SMP_MIN);
    send_word(3'd1, SMP_MIN);
    drain_block();
    write_register(REG_B0, COEF_MIN);
    write_register(REG_A1, COEF_MAX);
    write_register(REG_A2, COEF_MAX);
    send_word(3'd2, SMP_MAX);
    send_word(3'd2, SMP_MIN);
    send_word(3'd0, '0);
    send_word(3'd1, SMP_MAX);
    drain_block();
  endtask

  // Only the lowest channels filter; the others pass through untouched.
  task automatic test_partial_channels();
    program_filter(SPAN_UNITY, SPAN_UNITY, 4'd3);
    send_word(3'd2, random_sample());
    send_word(3'd3, random_sample());
    send_word(3'd0, random_sample());
    send_word(3'd7, random_sample());
    send_word(3'd2, random_sample());
    drain_block();
  endtask

  // Random words over several settings, with one full pause in each phase.
  task automatic test_random_traffic();
    logic [ACT_W-1:0] act;
    for (int p = 0; p < PHASES; p++) begin
      act = ($urandom_range(0, 3) == 0) ? ACT_W'($urandom_range(0, 15)) : ACT_W'(CHANNELS);
      case (p % 3)
        0: program_filter(SPAN_UNITY, SPAN_DOUBLE, act);
        1: program_filter(SPAN_FULL, SPAN_FULL, act);
        default: program_filter(SPAN_FULL, SPAN_UNITY, act);
      endcase
      steady_send = (p == 2);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i == PHASE_WORDS / 2) drain_block();
        send_word(CH_W'($urandom_range(0, CHANNELS - 1)), random_sample());
      end
      drain_block();
    end
    steady_send = 1'b0;
  endtask

  // Receiver readiness follows a rotating pattern that is re-drawn now and then.
  always @(posedge clk) begin
    if (pattern_age == 0) begin
      pattern_age = $urandom_range(20, 120);
      if ($urandom_range(0, 3) == 0) ready_pattern = '1;
      else ready_pattern = 16'($urandom()) | 16'h0001;
    end else begin
      pattern_age = pattern_age - 1;
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
    out_ready <= ready_pattern[0];
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    expected_word_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        note_failure($sformatf("unexpected result word %0d", out_sample_out));
      end else begin
        exp_word = pending_samples.pop_front();
        if (out_sample_out !== exp_word.sample) begin
          note_failure($sformatf("sample mismatch on channel %0d: expected %0d, got %0d",
                                 exp_word.channel, exp_word.sample, out_sample_out));
        end
      end
    end
  end

  // Watchdog: ends the run after too long without any handshake.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_channel   = '0;
    in_sample_in = '0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    coef_mirror  = '{b0: B0_RESET, b1: '0, b2: '0, a1: '0, a2: '0, active: '0};
    for (int c = 0; c < CHANNELS; c++) delay_mirror[c] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_passthrough();
    test_unity_and_spare_registers();
    test_saturation();
    test_partial_channels();
    test_random_traffic();

    drain_block();
    if (pending_samples.size() != 0) note_failure("expected words left at end of run");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
